### src/assert_macros.svh
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define GLCP_ASSERT_NOW(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
        else $error("glcp assertion failed");

// next-cycle implication, off during reset
`define GLCP_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
        else $error("glcp assertion failed");

// next-cycle implication, checked through reset as well
`define GLCP_ASSERT_NEXT_ALWAYS(lbl, clk, a, c) \
    lbl: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("glcp assertion failed");

`endif

### src/glcp_pkg.sv
package glcp_pkg;

    localparam int COLS    = 8;
    localparam int QUADS   = 4;
    localparam int WORD_W  = 8 * QUADS;
    localparam int PKT_MAX = 9;

    localparam logic [5:0] TIMEOUT_RESET = 6'd40;
    localparam logic [5:0] IDLE_MAX      = 6'd63;

    // command codes (high nibble of the first byte)
    localparam logic [3:0] K_SET   = 4'd2;
    localparam logic [3:0] K_CLR   = 4'd3;
    localparam logic [3:0] K_ROW   = 4'd4;
    localparam logic [3:0] K_COL   = 4'd5;
    localparam logic [3:0] K_ROW2  = 4'd6;
    localparam logic [3:0] K_COL2  = 4'd7;
    localparam logic [3:0] K_FRAME = 4'd8;
    localparam logic [3:0] K_FILL  = 4'd9;
    localparam logic [3:0] K_INT   = 4'd10;
    localparam logic [3:0] K_MODE  = 4'd11;
    localparam logic [3:0] K_FIRST_BAD = 4'd12;

    localparam logic [1:0] MODE_OFF = 2'd3;
    localparam logic [1:0] MODE_SLEEP = 2'd2;
    localparam logic [1:0] MODE_TEST = 2'd1;

    // driver registers
    localparam logic [3:0] REG_INTENSITY = 4'd10;
    localparam logic [3:0] REG_SHUTDOWN  = 4'd12;
    localparam logic [3:0] REG_TEST      = 4'd15;

    typedef logic [PKT_MAX-1:0][7:0] t_pkt;

    typedef struct packed {
        logic       start;
        logic [3:0] kind;
        t_pkt       bytes;
    } t_cmd;

    function automatic logic [3:0] pkt_len(input logic [3:0] kind);
        logic [3:0] len;
        unique case (kind)
            K_ROW2, K_COL2: len = 4'd3;
            K_FRAME:        len = 4'd9;
            K_FILL, K_INT, K_MODE: len = 4'd1;
            default:        len = 4'd2;
        endcase
        return len;
    endfunction

    // new content of one column (all four quadrants) after a packet
    function automatic logic [WORD_W-1:0] col_update(input logic [3:0] kind,
                                                     input t_pkt b,
                                                     input logic [2:0] c,
                                                     input logic [WORD_W-1:0] old);
        logic [WORD_W-1:0] w;
        logic [7:0] mask;
        logic [1:0] q;
        logic [7:0] fb;
        w = old;
        mask = 8'd0;
        q = 2'd0;
        fb = 8'd0;
        unique case (kind)
            K_SET, K_CLR: begin
                q = {b[1][3], b[1][7]};
                mask = 8'd1 << b[1][2:0];
                if (kind == K_SET) begin
                    w[{q, 3'b000} +: 8] = old[{q, 3'b000} +: 8] | mask;
                end else begin
                    w[{q, 3'b000} +: 8] = old[{q, 3'b000} +: 8] & ~mask;
                end
            end
            K_ROW, K_ROW2: begin
                mask = 8'd1 << b[0][2:0];
                q = {b[0][3], 1'b0};
                w[{q, 3'b000} +: 8] = b[1][c] ? (old[{q, 3'b000} +: 8] | mask)
                                              : (old[{q, 3'b000} +: 8] & ~mask);
                if (kind == K_ROW2) begin
                    w[{b[0][3], 1'b1, 3'b000} +: 8] =
                        b[2][c] ? (old[{b[0][3], 1'b1, 3'b000} +: 8] | mask)
                                : (old[{b[0][3], 1'b1, 3'b000} +: 8] & ~mask);
                end
            end
            K_COL, K_COL2: begin
                w[{1'b0, b[0][3], 3'b000} +: 8] = b[1];
                if (kind == K_COL2) begin
                    w[{1'b1, b[0][3], 3'b000} +: 8] = b[2];
                end
            end
            K_FRAME: begin
                q = b[0][1:0];
                for (int r = 0; r < COLS; r++) begin
                    fb[r] = b[r+1][c];
                end
                w[{q, 3'b000} +: 8] = fb;
            end
            K_FILL: w = {WORD_W{b[0][0]}};
            default: w = old;
        endcase
        return w;
    endfunction

endpackage

### src/glcp_ram.sv
module glcp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/glcp_parser.sv
module glcp_parser import glcp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_func,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    input  logic       i_busy,
    output t_cmd       o_cmd
);

    logic [5:0] r_limit;
    logic [3:0] r_count, n_count;
    logic [3:0] r_len, n_len;
    logic [3:0] r_kind, n_kind;
    logic [5:0] r_idle, n_idle;
    logic       r_start, n_start;
    t_pkt       r_pkt;
    logic       acc;
    logic       wr_en;
    logic [3:0] wr_idx;
    logic       took;

    assign o_ready = !i_busy && !r_start;
    assign acc = i_valid && o_ready;

    always_comb begin
        n_count = r_count;
        n_len = r_len;
        n_kind = r_kind;
        n_idle = r_idle;
        n_start = 1'b0;
        wr_en = 1'b0;
        wr_idx = r_count;
        took = 1'b0;
        if (acc) begin
            if (i_func) begin
                if (r_idle > r_limit) begin
                    n_count = 4'd0;
                end else if (r_idle != IDLE_MAX) begin
                    n_idle = r_idle + 6'd1;
                end
            end else if (r_count == 4'd0) begin
                if (i_rx_byte[7:4] < K_FIRST_BAD) begin
                    n_kind = i_rx_byte[7:4];
                    n_len = pkt_len(i_rx_byte[7:4]);
                    wr_en = 1'b1;
                    n_count = 4'd1;
                    n_idle = 6'd0;
                    took = 1'b1;
                end
            end else begin
                wr_en = (r_count < 4'(PKT_MAX));
                n_count = r_count + 4'd1;
                took = 1'b1;
            end
            if (took && n_count == n_len) begin
                n_count = 4'd0;
                n_start = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= TIMEOUT_RESET;
            r_count <= 4'd0;
            r_len <= 4'd1;
            r_kind <= 4'd0;
            r_idle <= 6'd0;
            r_start <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_count <= n_count;
            r_len <= n_len;
            r_kind <= n_kind;
            r_idle <= n_idle;
            r_start <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pkt[wr_idx] <= i_rx_byte;
        end
    end

    assign o_cmd.start = r_start;
    assign o_cmd.kind = r_kind;
    assign o_cmd.bytes = r_pkt;

endmodule

### src/glcp_engine.sv
module glcp_engine import glcp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output logic                     o_busy,
    output logic                     o_ram_we,
    output logic [$clog2(COLS)-1:0]  o_ram_addr,
    output logic [WORD_W-1:0]        o_ram_wdata,
    output logic                     o_ram_re,
    input  logic [WORD_W-1:0]        i_ram_rdata,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [3:0]               o_driver_register,
    output logic [7:0]               o_chip0_data,
    output logic [7:0]               o_chip1_data,
    output logic [7:0]               o_chip2_data,
    output logic [7:0]               o_chip3_data,
    output logic                     o_last
);

    typedef enum logic [1:0] {E_IDLE, E_READ, E_MOD, E_CONST} t_state;

    t_state                    r_state;
    logic [$clog2(COLS)-1:0]   r_col;
    logic                      r_all;
    logic                      r_step;
    logic [COLS-1:0]           r_vld;
    logic                      r_rd_vld;
    logic                      out_free;
    logic [WORD_W-1:0]         old_word;
    logic [WORD_W-1:0]         new_word;
    logic                      col_last;
    logic [1:0]                mode;
    logic [7:0]                mode_val;

    assign out_free = !o_valid || i_ready;
    assign old_word = r_rd_vld ? i_ram_rdata : '0;
    assign new_word = col_update(i_cmd.kind, i_cmd.bytes, r_col, old_word);
    assign col_last = !r_all || (r_col == 3'(COLS - 1));
    assign mode = i_cmd.bytes[0][1:0];
    assign mode_val = r_step ? {7'd0, mode == MODE_TEST} : {7'd0, mode != MODE_SLEEP};

    assign o_busy = (r_state != E_IDLE);
    assign o_ram_re = (r_state == E_READ);
    assign o_ram_we = (r_state == E_MOD) && out_free;
    assign o_ram_addr = r_col;
    assign o_ram_wdata = new_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_vld <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                E_IDLE: begin
                    if (i_cmd.start) begin
                        r_step <= 1'b0;
                        unique case (i_cmd.kind)
                            K_SET, K_CLR: begin
                                r_col <= i_cmd.bytes[1][6:4];
                                r_all <= 1'b0;
                                r_state <= E_READ;
                            end
                            K_COL, K_COL2: begin
                                r_col <= i_cmd.bytes[0][2:0];
                                r_all <= 1'b0;
                                r_state <= E_READ;
                            end
                            K_ROW, K_ROW2, K_FRAME, K_FILL: begin
                                r_col <= '0;
                                r_all <= 1'b1;
                                r_state <= E_READ;
                            end
                            K_INT: r_state <= E_CONST;
                            K_MODE: begin
                                if (mode != MODE_OFF) begin
                                    r_state <= E_CONST;
                                end
                            end
                            default: r_state <= E_IDLE;
                        endcase
                    end
                end
                E_READ: begin
                    r_rd_vld <= r_vld[r_col];
                    r_state <= E_MOD;
                end
                E_MOD: begin
                    if (out_free) begin
                        o_valid <= 1'b1;
                        o_driver_register <= {1'b0, r_col} + 4'd1;
                        o_chip0_data <= new_word[7:0];
                        o_chip1_data <= new_word[15:8];
                        o_chip2_data <= new_word[23:16];
                        o_chip3_data <= new_word[31:24];
                        o_last <= col_last;
                        r_vld[r_col] <= 1'b1;
                        if (col_last) begin
                            r_state <= E_IDLE;
                        end else begin
                            r_col <= r_col + 3'd1;
                            r_state <= E_READ;
                        end
                    end
                end
                E_CONST: begin
                    if (out_free) begin
                        o_valid <= 1'b1;
                        if (i_cmd.kind == K_INT) begin
                            o_driver_register <= REG_INTENSITY;
                            o_chip0_data <= {4'd0, i_cmd.bytes[0][3:0]};
                            o_chip1_data <= {4'd0, i_cmd.bytes[0][3:0]};
                            o_chip2_data <= {4'd0, i_cmd.bytes[0][3:0]};
                            o_chip3_data <= {4'd0, i_cmd.bytes[0][3:0]};
                            o_last <= 1'b1;
                            r_state <= E_IDLE;
                        end else begin
                            o_driver_register <= r_step ? REG_TEST : REG_SHUTDOWN;
                            o_chip0_data <= mode_val;
                            o_chip1_data <= mode_val;
                            o_chip2_data <= mode_val;
                            o_chip3_data <= mode_val;
                            o_last <= r_step;
                            r_step <= 1'b1;
                            if (r_step) begin
                                r_state <= E_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

endmodule

### src/grid_led_command_parser_top.sv
// grid LED command parser
// input channel (i_valid / o_ready): one beat is either a received protocol
// byte (i_func = 0, i_rx_byte) or a loop tick (i_func = 1)
// output channel (o_valid / i_ready): one beat is one LED driver write,
// register address plus a data byte for each of the four quadrant chips;
// o_last marks the final write caused by one input beat
// config: i_cfg_we writes the 6-bit timeout limit; the user writes it only
// while idle, the block does not enforce it; the frame store is an 8-entry
// x 32-bit memory, one entry per column holding all four quadrants; each
// column costs one read and one write; a byte that completes a packet sets
// the registered start strobe, which starts the update; a column update
// reads the frame store, writes it back and loads the output register, for
// all eight columns in a full refresh; intensity/mode writes skip the store
// input beats are not taken while an update runs
// when the receiver stalls, the update waits with its column read held
// reset (synchronous, active low) clears the parser, the per-column valid
// bits (the frame store then reads as all zero) and the output valid flag
module grid_led_command_parser_top import glcp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_func,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_driver_register,
    output logic [7:0] o_chip0_data,
    output logic [7:0] o_chip1_data,
    output logic [7:0] o_chip2_data,
    output logic [7:0] o_chip3_data,
    output logic       o_last
);

    t_cmd                    cmd;
    logic                    busy;
    logic                    ram_we;
    logic                    ram_re;
    logic [$clog2(COLS)-1:0] ram_addr;
    logic [WORD_W-1:0]       ram_wdata;
    logic [WORD_W-1:0]       ram_rdata;

    glcp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_busy      (busy),
        .o_cmd       (cmd)
    );

    glcp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (COLS)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    glcp_engine u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_busy            (busy),
        .o_ram_we          (ram_we),
        .o_ram_addr        (ram_addr),
        .o_ram_wdata       (ram_wdata),
        .o_ram_re          (ram_re),
        .i_ram_rdata       (ram_rdata),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_driver_register (o_driver_register),
        .o_chip0_data      (o_chip0_data),
        .o_chip1_data      (o_chip1_data),
        .o_chip2_data      (o_chip2_data),
        .o_chip3_data      (o_chip3_data),
        .o_last            (o_last)
    );

endmodule

### src/glcp_checker.sv
`include "assert_macros.svh"

module glcp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [3:0] o_driver_register,
    input logic [7:0] o_chip0_data,
    input logic       o_last
);

    // a stalled write beat holds
    `GLCP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_driver_register) && $stable(o_chip0_data) && $stable(o_last))

    // while a burst is unfinished no new input beat is taken
    `GLCP_ASSERT_NOW(a_burst_blocks, i_clk, i_rst_n, o_valid && !o_last, !o_ready)

    // only column, intensity, shutdown and test registers are written
    `GLCP_ASSERT_NOW(a_reg_known, i_clk, i_rst_n, o_valid,
        (o_driver_register >= 4'd1 && o_driver_register <= 4'd8) ||
        o_driver_register == 4'd10 || o_driver_register == 4'd12 ||
        o_driver_register == 4'd15)

    // reset leaves the output empty
    `GLCP_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_valid)

endmodule

bind grid_led_command_parser_top glcp_checker u_glcp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_driver_register (o_driver_register),
    .o_chip0_data      (o_chip0_data),
    .o_last            (o_last)
);
